// ===== hdl/cfd_pkg.sv =====
// shared types and constants for the command frame deframer
// no dependencies; every other file imports this package

package cfd_pkg;

    localparam int CMD_LIMIT   = 16;
    localparam int STORE_DEPTH = CMD_LIMIT + 5;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int LEN_W       = 5;

    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_START = 8'h3C;  // '<'
    localparam logic [7:0] CH_END   = 8'h3E;  // '>'
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_H     = 8'h48;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_UNKNOWN  = 2'd1,
        KIND_TOO_LONG = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_TYPE,
        ST_DEV,
        ST_DATA,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        kind_t             kind;
        logic              device_type;
        logic              device_num;
        logic [7:0]        payload_byte;
        logic              byte_valid;
        logic [LEN_W-1:0]  payload_length;
        logic              last;
    } res_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } ram_req_t;

endpackage

// ===== hdl/cfd_if.sv =====
// valid/ready channel interfaces for the received bytes and the results
// depends on cfd_pkg

interface cfd_link_if;
    import cfd_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface cfd_result_if;
    import cfd_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       kind;
    logic             device_type;
    logic             device_num;
    logic [7:0]       payload_byte;
    logic             byte_valid;
    logic [LEN_W-1:0] payload_length;
    logic             last;

    modport source (output valid, output kind, output device_type, output device_num,
                    output payload_byte, output byte_valid, output payload_length,
                    output last, input ready);
    modport sink   (input valid, input kind, input device_type, input device_num,
                    input payload_byte, input byte_valid, input payload_length,
                    input last, output ready);
endinterface

// ===== hdl/cfd_ram.sv =====
// payload store: one write port, one read port with registered read data
// depends on cfd_pkg

module cfd_ram (
    input  logic            clk,
    input  cfd_pkg::ram_req_t req,
    output logic [7:0]      rd_data
);
    import cfd_pkg::*;

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        // read data holds until the next read request
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/cfd_ctrl.sv =====
// frame parser and readout sequencer around the payload store
// depends on cfd_pkg

module cfd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    output logic              in_ready,
    input  logic              slot_free,
    output logic              push,
    output cfd_pkg::res_t     res,
    output cfd_pkg::ram_req_t ram_req,
    input  logic [7:0]        rd_data
);
    import cfd_pkg::*;

    state_t           state_reg, state_next;
    logic             type_reg, type_next;
    logic             dev_reg, dev_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] issued_reg, issued_next;
    logic             pend_reg, pend_next;
    logic             pend_last_reg, pend_last_next;

    logic accept;
    logic crlf;
    logic move;
    logic issue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_HUNT;
            type_reg      <= 1'b0;
            dev_reg       <= 1'b0;
            count_reg     <= '0;
            issued_reg    <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            type_reg      <= type_next;
            dev_reg       <= dev_next;
            count_reg     <= count_next;
            issued_reg    <= issued_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
        end
    end

    assign in_ready = (state_reg != ST_DRAIN) && slot_free;
    assign accept   = in_valid && in_ready;
    assign crlf     = (in_byte == CH_LF) || (in_byte == CH_CR);

    always_comb
    begin
        state_next     = state_reg;
        type_next      = type_reg;
        dev_next       = dev_reg;
        count_next     = count_reg;
        issued_next    = issued_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        push           = 1'b0;
        res            = '0;
        ram_req        = '0;
        ram_req.wr_addr = count_reg[ADDR_W-1:0];
        ram_req.wr_data = in_byte;
        ram_req.rd_addr = issued_reg[ADDR_W-1:0];
        move           = 1'b0;
        issue          = 1'b0;

        case (state_reg)
            ST_HUNT:
            begin
                if (accept && !crlf && in_byte == CH_START)
                begin
                    count_next = '0;
                    state_next = ST_TYPE;
                end
            end
            ST_TYPE:
            begin
                if (accept && !crlf)
                begin
                    if (in_byte == CH_F || in_byte == CH_R)
                    begin
                        type_next  = (in_byte == CH_R);
                        state_next = ST_DEV;
                    end
                    else
                    begin
                        push       = 1'b1;
                        res.kind   = KIND_UNKNOWN;
                        res.last   = 1'b1;
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_DEV:
            begin
                if (accept && !crlf)
                begin
                    count_next = '0;
                    if (in_byte == CH_ONE || in_byte == CH_H)
                    begin
                        dev_next   = (in_byte == CH_H);
                        state_next = ST_DATA;
                    end
                    else
                    begin
                        push       = 1'b1;
                        res.kind   = KIND_UNKNOWN;
                        res.last   = 1'b1;
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_DATA:
            begin
                if (accept && !crlf)
                begin
                    if (count_reg >= CNT_W'(STORE_DEPTH))
                    begin
                        push       = 1'b1;
                        res.kind   = KIND_TOO_LONG;
                        res.last   = 1'b1;
                        state_next = ST_HUNT;
                    end
                    else if (in_byte == CH_END)
                    begin
                        if (count_reg == '0)
                        begin
                            // empty frame gives one result with no data
                            push            = 1'b1;
                            res.kind        = KIND_DATA;
                            res.device_type = type_reg;
                            res.device_num  = dev_reg;
                            res.last        = 1'b1;
                            state_next      = ST_HUNT;
                        end
                        else
                        begin
                            issued_next    = '0;
                            pend_next      = 1'b0;
                            pend_last_next = 1'b0;
                            state_next     = ST_DRAIN;
                        end
                    end
                    else if (in_byte == CH_START)
                    begin
                        state_next = ST_TYPE;
                    end
                    else
                    begin
                        ram_req.wr_en = 1'b1;
                        count_next    = count_reg + 1'b1;
                    end
                end
            end
            ST_DRAIN:
            begin
                // one read in flight at most; the next read goes out as the
                // held read data moves into the output register
                move  = pend_reg && slot_free;
                issue = (!pend_reg || move) && (issued_reg != count_reg);
                push  = move;
                res.kind           = KIND_DATA;
                res.device_type    = type_reg;
                res.device_num     = dev_reg;
                res.payload_byte   = rd_data;
                res.byte_valid     = 1'b1;
                res.payload_length = LEN_W'(count_reg);
                res.last           = pend_last_reg;
                ram_req.rd_en      = issue;
                if (issue)
                begin
                    issued_next    = issued_reg + 1'b1;
                    pend_next      = 1'b1;
                    pend_last_next = (issued_reg + 1'b1 == count_reg);
                end
                else if (move)
                begin
                    pend_next = 1'b0;
                end
                if (move && pend_last_reg)
                begin
                    state_next = ST_HUNT;
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

endmodule

// ===== hdl/cfd_outreg.sv =====
// output register stage that holds a result until the sink takes it
// depends on cfd_pkg and cfd_result_if

module cfd_outreg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cfd_pkg::res_t res,
    output logic          slot_free,
    cfd_result_if.source  result
);
    import cfd_pkg::*;

    logic valid_reg;
    res_t data_reg;

    assign slot_free = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && push)
        begin
            data_reg <= res;
        end
    end

    assign result.valid          = valid_reg;
    assign result.kind           = data_reg.kind;
    assign result.device_type    = data_reg.device_type;
    assign result.device_num     = data_reg.device_num;
    assign result.payload_byte   = data_reg.payload_byte;
    assign result.byte_valid     = data_reg.byte_valid;
    assign result.payload_length = data_reg.payload_length;
    assign result.last           = data_reg.last;

endmodule

// ===== hdl/command_frame_deframer.sv =====
// top level of the command frame deframer
// depends on cfd_pkg, cfd_if, cfd_ram, cfd_ctrl and cfd_outreg

// Takes one received byte per cycle, while the output register is free,
// when parsing a frame header and collecting payload; line feed and
// carriage return are dropped. Payload bytes go into a small
// single-port-read memory. On the closing '>' of a non-empty frame the
// byte input is held off while the frame is read back, one result per
// cycle while the result sink does not stall. Errors and empty frames
// give a single result. A byte that causes a result is taken only when
// the output register is free or being emptied in the same cycle.

module command_frame_deframer (
    input  logic         clk,
    input  logic         rst_n,
    cfd_link_if.sink     link,
    cfd_result_if.source result
);
    import cfd_pkg::*;

    ram_req_t   ram_req;
    logic [7:0] rd_data;
    logic       slot_free;
    logic       push;
    res_t       res;

    cfd_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    cfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (link.valid),
        .in_byte   (link.in_byte),
        .in_ready  (link.ready),
        .slot_free (slot_free),
        .push      (push),
        .res       (res),
        .ram_req   (ram_req),
        .rd_data   (rd_data)
    );

    cfd_outreg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .res       (res),
        .slot_free (slot_free),
        .result    (result)
    );

endmodule

// ===== hdl/cfd_checker.sv =====
// port-level checks for the command frame deframer, bound to the top level
// depends on cfd_pkg

module cfd_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    link_ready,
    input logic                    res_valid,
    input logic                    res_ready,
    input logic [1:0]              kind,
    input logic                    byte_valid,
    input logic [cfd_pkg::LEN_W-1:0] payload_length,
    input logic                    last
);
    import cfd_pkg::*;

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind != KIND_DATA |-> last && !byte_valid && payload_length == '0)
        else $error("error result not a single last result");

    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && byte_valid |-> payload_length != '0 && kind == KIND_DATA)
        else $error("data byte with zero length");

    // input is held off while a non-last result of a frame is offered
    a_readout_lock: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !last |-> !link_ready)
        else $error("byte taken during frame readout");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> kind != 2'd3)
        else $error("undefined result kind");

endmodule

bind command_frame_deframer cfd_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .link_ready     (link.ready),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .kind           (result.kind),
    .byte_valid     (result.byte_valid),
    .payload_length (result.payload_length),
    .last           (result.last)
);

// ===== tb/sv/cfd_checker.sv =====
// scoreboard for the command frame deframer: watches both channels, parses
// the accepted bytes on its own and compares every result field by field
// depends on cfd_pkg and cfd_if

module cfd_scoreboard (
    input  logic  clk,
    input  logic  rst_n,
    cfd_link_if   link,
    cfd_result_if result,
    output int    mismatches,
    output int    owed_results
);
    import cfd_pkg::*;

    typedef enum logic [1:0] {
        P_HUNT,
        P_TYPE,
        P_DEVICE,
        P_PAYLOAD
    } parse_phase_t;

    parse_phase_t phase;
    logic         frame_is_r;
    logic         frame_is_h;
    int           fill;
    logic [7:0]   payload_mem [STORE_DEPTH];
    res_t         frame_results_q [$];
    res_t         want;

    function automatic res_t make_result(kind_t k, logic dt, logic dn, logic [7:0] pb,
                                         logic bv, logic [LEN_W-1:0] len, logic lst);
        res_t r;
        r.kind           = k;
        r.device_type    = dt;
        r.device_num     = dn;
        r.payload_byte   = pb;
        r.byte_valid     = bv;
        r.payload_length = len;
        r.last           = lst;
        return r;
    endfunction

    task automatic parse_byte(input logic [7:0] b);
        int i;
        if (b == CH_LF || b == CH_CR)
            return;
        case (phase)
            P_HUNT:
            begin
                if (b == CH_START)
                begin
                    fill  = 0;
                    phase = P_TYPE;
                end
            end
            P_TYPE:
            begin
                if (b == CH_F || b == CH_R)
                begin
                    frame_is_r = (b == CH_R);
                    phase      = P_DEVICE;
                end
                else
                begin
                    // a bad type byte is consumed even when it is a start marker
                    phase = P_HUNT;
                    frame_results_q.push_back(make_result(KIND_UNKNOWN, 1'b0, 1'b0, 8'd0,
                                                          1'b0, '0, 1'b1));
                end
            end
            P_DEVICE:
            begin
                fill = 0;
                if (b == CH_ONE || b == CH_H)
                begin
                    frame_is_h = (b == CH_H);
                    phase      = P_PAYLOAD;
                end
                else
                begin
                    phase = P_HUNT;
                    frame_results_q.push_back(make_result(KIND_UNKNOWN, 1'b0, 1'b0, 8'd0,
                                                          1'b0, '0, 1'b1));
                end
            end
            default:
            begin
                if (fill >= STORE_DEPTH)
                begin
                    // store full: whatever comes next is swallowed as the error
                    phase = P_HUNT;
                    frame_results_q.push_back(make_result(KIND_TOO_LONG, 1'b0, 1'b0, 8'd0,
                                                          1'b0, '0, 1'b1));
                end
                else if (b == CH_END)
                begin
                    phase = P_HUNT;
                    if (fill == 0)
                        frame_results_q.push_back(make_result(KIND_DATA, frame_is_r,
                                                              frame_is_h, 8'd0, 1'b0, '0,
                                                              1'b1));
                    else
                        for (i = 0; i < fill; i++)
                            frame_results_q.push_back(make_result(KIND_DATA, frame_is_r,
                                frame_is_h, payload_mem[i], 1'b1, fill[LEN_W-1:0],
                                i == fill - 1));
                end
                else if (b == CH_START)
                    phase = P_TYPE;
                else
                begin
                    payload_mem[fill] = b;
                    fill++;
                end
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [7:0] exp, input logic [7:0] act);
        if (exp !== act)
        begin
            $error("%s: expected %0d, got %0d", name, exp, act);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase        = P_HUNT;
            frame_is_r   = 1'b0;
            frame_is_h   = 1'b0;
            fill         = 0;
            mismatches   = 0;
            owed_results = 0;
            frame_results_q.delete();
        end
        else
        begin
            if (link.valid && link.ready)
                parse_byte(link.in_byte);
            if (result.valid && result.ready)
            begin
                if (frame_results_q.size() == 0)
                begin
                    $error("unexpected result: kind %0d payload_byte %0d last %0d",
                           result.kind, result.payload_byte, result.last);
                    mismatches++;
                end
                else
                begin
                    want = frame_results_q.pop_front();
                    compare_field("kind", 8'(want.kind), 8'(result.kind));
                    compare_field("device_type", 8'(want.device_type), 8'(result.device_type));
                    compare_field("device_num", 8'(want.device_num), 8'(result.device_num));
                    compare_field("payload_byte", want.payload_byte, result.payload_byte);
                    compare_field("byte_valid", 8'(want.byte_valid), 8'(result.byte_valid));
                    compare_field("payload_length", 8'(want.payload_length),
                                  8'(result.payload_length));
                    compare_field("last", 8'(want.last), 8'(result.last));
                end
            end
            owed_results = frame_results_q.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// top of the deframer testbench: clock, reset, byte stream and result sink
// depends on cfd_pkg, cfd_if, cfd_checker and the command_frame_deframer rtl

module testbench;
    import cfd_pkg::*;

    localparam int          BYTE_TARGET = 410;
    localparam int          WATCHDOG    = 2000;
    localparam int          LONG_HOLD   = 250;
    localparam logic [7:0]  OPENING [27] = '{
        CH_LF, CH_END,
        CH_START, CH_F, CH_H, CH_END,
        CH_START, CH_R, CH_LF, CH_ONE, 8'h00, 8'hFF, CH_CR, CH_END,
        CH_START, CH_START,
        CH_START, CH_F, 8'h51,
        CH_START, CH_R, CH_H, 8'h61, CH_START, CH_F, CH_ONE, CH_END
    };

    logic       clk;
    logic       rst_n;
    int         mismatches;
    int         owed_results;
    int         bytes_sent;
    int         counted;
    int         stall_left;
    int         sink_cycles;
    int         quiet_cycles;
    int         k;
    int         sel;
    int         n;
    bit         long_hold_done;
    logic [7:0] line_bytes [$];

    cfd_link_if   link();
    cfd_result_if result();

    command_frame_deframer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .link   (link),
        .result (result)
    );

    cfd_scoreboard chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .link         (link),
        .result       (result),
        .mismatches   (mismatches),
        .owed_results (owed_results)
    );

    function automatic void queue_byte(input logic [7:0] b);
        line_bytes.push_back(b);
        if (b != CH_LF && b != CH_CR)
            counted++;
    endfunction

    function automatic logic [7:0] payload_value();
        logic [7:0] v;
        do
            v = 8'($urandom_range(0, 255));
        while (v == CH_START || v == CH_END);
        return v;
    endfunction

    // any byte that is neither a valid type, a valid device byte, a line feed nor a carriage return
    function automatic logic [7:0] bad_header_byte();
        logic [7:0] v;
        do
            v = 8'($urandom_range(0, 255));
        while (v == CH_F || v == CH_R || v == CH_ONE || v == CH_H || v == CH_LF || v == CH_CR);
        return v;
    endfunction

    function automatic void queue_header();
        queue_byte(CH_START);
        queue_byte($urandom_range(0, 1) ? CH_R : CH_F);
        queue_byte($urandom_range(0, 1) ? CH_H : CH_ONE);
    endfunction

    function automatic void queue_payload(input int len);
        int i;
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                queue_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
            queue_byte(payload_value());
        end
    endfunction

    function automatic int frame_size();
        if ($urandom_range(0, 7) != 0)
            return $urandom_range(0, 6);
        return $urandom_range(0, 1) ? STORE_DEPTH - 1 : $urandom_range(7, STORE_DEPTH - 1);
    endfunction

    function automatic void build_stream();
        logic [7:0] v;
        foreach (OPENING[i])
            queue_byte(OPENING[i]);
        while (counted < BYTE_TARGET)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
            begin
                // line noise while hunting
                n = $urandom_range(1, 4);
                repeat (n) line_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else if (sel < 15)
            begin
                queue_byte(CH_START);
                queue_byte(bad_header_byte());
            end
            else if (sel < 22)
            begin
                queue_byte(CH_START);
                queue_byte($urandom_range(0, 1) ? CH_R : CH_F);
                queue_byte(bad_header_byte());
            end
            else if (sel < 30)
            begin
                queue_header();
                queue_payload(STORE_DEPTH);
                do
                    v = 8'($urandom_range(0, 255));
                while (v == CH_LF || v == CH_CR);
                queue_byte(v);
            end
            else if (sel < 38)
            begin
                // start marker in the middle of the payload
                queue_header();
                queue_payload($urandom_range(0, 8));
                queue_byte(CH_START);
                queue_byte($urandom_range(0, 1) ? CH_R : CH_F);
                queue_byte($urandom_range(0, 1) ? CH_H : CH_ONE);
                queue_payload(frame_size());
                queue_byte(CH_END);
            end
            else
            begin
                queue_header();
                queue_payload(frame_size());
                queue_byte(CH_END);
            end
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // byte source and verdict
    initial
    begin
        rst_n        <= 1'b0;
        link.valid   <= 1'b0;
        link.in_byte <= 8'd0;
        bytes_sent   = 0;
        counted      = 0;
        build_stream();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (k = 0; k < line_bytes.size(); k++)
        begin
            if (k < line_bytes.size() - 60 && (k / 50) % 3 != 2 && $urandom_range(0, 3) == 0)
            begin
                link.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            link.valid   <= 1'b1;
            link.in_byte <= line_bytes[k];
            @(posedge clk);
            while (!link.ready)
                @(posedge clk);
            bytes_sent = k + 1;
        end
        link.valid <= 1'b0;
        @(posedge clk);
        while (owed_results != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (mismatches == 0 && owed_results == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // result sink: random stalls plus one long hold-off so the block backs up
    initial
    begin
        result.ready   <= 1'b0;
        stall_left     = 0;
        sink_cycles    = 0;
        long_hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            sink_cycles++;
            if (stall_left > 0)
                stall_left--;
            else if (!long_hold_done && bytes_sent >= 120)
            begin
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD;
            end
            else if (bytes_sent < line_bytes.size() - 60 && (sink_cycles / 64) % 3 != 1
                     && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 12);
            result.ready <= (stall_left == 0);
        end
    end

    // no transfer on either side for too long means the block is stuck
    initial
    begin
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if ((link.valid && link.ready) || (result.valid && result.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule

// ===== sim.f =====
hdl/cfd_pkg.sv
hdl/cfd_if.sv
hdl/cfd_ram.sv
hdl/cfd_ctrl.sv
hdl/cfd_outreg.sv
hdl/command_frame_deframer.sv
hdl/cfd_checker.sv
tb/sv/cfd_checker.sv
tb/sv/testbench.sv
